// ----- rtl/nnt_pkg.sv -----
// Package for the nearest-neighbor tour block: beat structs, command codes and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nnt_pkg;
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]  city_index;
    logic [30:0] tour_length;
    logic        last;
    logic [1:0]  status;
  } out_beat_t;
endpackage
`default_nettype wire

// ----- rtl/nnt_isqrt.sv -----
// Multi-cycle floor integer square root of a 50-bit value, one result bit per cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none
module nnt_isqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [49:0] radicand,
  output logic             done,
  output logic [24:0]      root
);
  logic [49:0] rem_r, rem_nxt;
  logic [49:0] res_r, res_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [51:0] trial;
  logic [51:0] bitv;

  // Classic restoring digit recurrence; bit walks from 2^48 down by fours.
  // The partial result carries the scaled root and only narrows to 25 bits at the end.
  always_comb begin
    bitv = 52'd1 << {step_r, 1'b0};
    trial = {2'b00, res_r} + bitv;
    rem_nxt = rem_r;
    res_nxt = res_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = radicand;
      res_nxt = '0;
      step_nxt = 5'd24;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ({2'b00, rem_r} >= trial) begin
        rem_nxt = rem_r - trial[49:0];
        res_nxt = 50'((({2'b00, res_r} >> 1) + bitv));
      end else begin
        res_nxt = res_r >> 1;
      end
      if (step_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
    step_r <= step_nxt;
  end

  assign done = done_r;
  assign root = res_r[24:0];
endmodule
`default_nettype wire

// ----- rtl/nearest_neighbour_tour.sv -----
// Top level of the greedy nearest-neighbor tour block.
// Depends on nnt_pkg and nnt_isqrt.
`timescale 1ns / 1ps
`default_nettype none
// Loads and clears are handled in the idle state. A run over N cities does
// N-1 scans; each scan reads every city from the coordinate memory, one per
// cycle, and then drains the scan pipeline (read register, squaring registers,
// compare stage). Each leg also passes through the start, read-current and
// pick states, the bit-serial square-root unit and the hand-off of its result
// beat. The closing leg back to city 0 reads one city. The coordinate
// memory's single read port sets the scan rate. One item is worked on at a
// time; the input is stalled until every result of a run has been accepted.
// Results leave through a one-entry output register.
module nearest_neighbour_tour #(
  parameter int MAX_CITIES = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire nnt_pkg::in_beat_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output nnt_pkg::out_beat_t     out_data
);
  localparam int AW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int CW = $clog2(MAX_CITIES + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_CITIES);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_RDCUR, S_SCAN, S_PICK, S_SQRT, S_EMIT, S_WAIT
  } state_t;

  // Coordinate memory, x and y side by side, one read and one write port.
  logic [47:0] mem [MAX_CITIES];
  logic [47:0] rd_data_r;
  logic [AW-1:0] rd_addr;

  state_t        state_r;
  logic [CW-1:0] count_r;
  logic          dropped_r;
  logic [MAX_CITIES-1:0] visited_r;
  logic [AW-1:0] cur_r;
  logic [30:0]   total_r;
  logic [1:0]    status_r;
  logic [CW-1:0] pos_r;
  logic          closing_r;
  logic signed [23:0] cur_x_r, cur_y_r;
  logic [CW-1:0] scan_r;
  logic [AW-1:0] idx_d1_r, idx_d2_r;
  logic          vld_d1_r, vld_d2_r, rdcur_r;
  logic [AW-1:0] best_r;
  logic [49:0]   best_sq_r;
  logic          found_r;
  logic          ovalid_r;
  nnt_pkg::out_beat_t obeat_r;

  logic          sq_start;
  logic          sq_done;
  logic [24:0]   sq_root;
  logic signed [24:0] dx, dy;
  logic [23:0]   ax, ay;
  logic [49:0]   sum_sq;
  logic [31:0]   tot_sum;

  // Stage two of the scan: absolute differences, squared, each into a register.
  assign dx = 25'(signed'(rd_data_r[47:24])) - 25'(cur_x_r);
  assign dy = 25'(signed'(rd_data_r[23:0])) - 25'(cur_y_r);
  assign ax = dx[24] ? 24'(-dx) : dx[23:0];
  assign ay = dy[24] ? 24'(-dy) : dy[23:0];

  logic [47:0] sqx_r, sqy_r;
  always_ff @(posedge clk) begin
    sqx_r <= ax * ax;
    sqy_r <= ay * ay;
  end
  assign sum_sq = {2'b00, sqx_r} + {2'b00, sqy_r};

  assign tot_sum = {1'b0, total_r} + {7'd0, sq_root};

  nnt_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (best_sq_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign in_stall  = (state_r != S_IDLE) || ovalid_r;
  assign out_valid = ovalid_r;
  assign out_data  = obeat_r;
  assign sq_start  = (state_r == S_PICK);

  // Read address: the current city while fetching it, otherwise the scan index.
  always_comb begin
    if (state_r == S_RDCUR) begin
      rd_addr = cur_r;
    end else begin
      rd_addr = scan_r[AW-1:0];
    end
  end

  // Memory write on load, registered read.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && !ovalid_r && in_valid &&
        in_data.command == nnt_pkg::CMD_LOAD && count_r < CNT_FULL) begin
      mem[count_r[AW-1:0]] <= {in_data.coord_x, in_data.coord_y};
    end
    rd_data_r <= mem[rd_addr];
  end

  // Sequencer, scan pipeline and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      dropped_r <= 1'b0;
      visited_r <= '0;
      cur_r     <= '0;
      total_r   <= '0;
      ovalid_r  <= 1'b0;
      vld_d1_r  <= 1'b0;
      vld_d2_r  <= 1'b0;
      rdcur_r   <= 1'b0;
    end else begin
      if (ovalid_r && !out_stall) begin
        ovalid_r <= 1'b0;
      end
      vld_d1_r <= 1'b0;
      vld_d2_r <= vld_d1_r;
      idx_d2_r <= idx_d1_r;
      rdcur_r  <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && !ovalid_r) begin
            case (in_data.command)
              nnt_pkg::CMD_LOAD: begin
                if (count_r < CNT_FULL) begin
                  count_r <= count_r + 1'b1;
                end else begin
                  dropped_r <= 1'b1;
                end
              end
              nnt_pkg::CMD_CLEAR: begin
                count_r   <= '0;
                dropped_r <= 1'b0;
              end
              nnt_pkg::CMD_RUN: begin
                if (count_r == '0) begin
                  obeat_r.city_index  <= '0;
                  obeat_r.tour_length <= '0;
                  obeat_r.last        <= 1'b1;
                  obeat_r.status      <= nnt_pkg::ST_EMPTY;
                  ovalid_r            <= 1'b1;
                end else begin
                  status_r  <= dropped_r ? nnt_pkg::ST_DROPPED : nnt_pkg::ST_OK;
                  visited_r <= MAX_CITIES'(1);
                  cur_r     <= '0;
                  total_r   <= '0;
                  pos_r     <= CW'(1);
                  closing_r <= 1'b0;
                  state_r   <= S_START;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_START: begin
          // Go on to fetch the current city's coordinates.
          state_r <= S_RDCUR;
        end
        S_RDCUR: begin
          rdcur_r <= 1'b1;
          scan_r  <= '0;
          found_r <= 1'b0;
          state_r <= S_SCAN;
          if (pos_r == count_r) begin
            closing_r <= 1'b1;
          end
        end
        S_SCAN: begin
          if (rdcur_r) begin
            cur_x_r <= signed'(rd_data_r[47:24]);
            cur_y_r <= signed'(rd_data_r[23:0]);
          end
          // Issue reads for every city; the closing leg reads only city 0.
          if (scan_r < (closing_r ? CW'(1) : count_r)) begin
            vld_d1_r <= closing_r || !visited_r[scan_r[AW-1:0]];
            idx_d1_r <= scan_r[AW-1:0];
            scan_r   <= scan_r + 1'b1;
          end else if (!vld_d1_r && !vld_d2_r && !rdcur_r) begin
            state_r <= S_PICK;
          end
          // Compare stage: strict less keeps the lowest index on ties.
          if (vld_d2_r && (!found_r || sum_sq < best_sq_r)) begin
            found_r   <= 1'b1;
            best_r    <= idx_d2_r;
            best_sq_r <= sum_sq;
          end
        end
        S_PICK: begin
          // The root unit takes the winning squared distance at this edge.
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_done) begin
            total_r <= tot_sum[31] ? nnt_pkg::LEN_MAX : tot_sum[30:0];
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!ovalid_r) begin
            obeat_r.city_index  <= 6'(cur_r);
            obeat_r.tour_length <= closing_r ? total_r : '0;
            obeat_r.last        <= closing_r;
            obeat_r.status      <= status_r;
            ovalid_r            <= 1'b1;
            if (closing_r) begin
              state_r <= S_WAIT;
            end else begin
              visited_r[best_r] <= 1'b1;
              cur_r   <= best_r;
              pos_r   <= pos_r + 1'b1;
              state_r <= S_START;
            end
          end
        end
        S_WAIT: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/nnt_checker.sv -----
// Port-level checker for the nearest-neighbor tour block, bound to the top level.
// Depends on nnt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nnt_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire nnt_pkg::in_beat_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire nnt_pkg::out_beat_t out_data
);
  // A stalled input beat holds.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input beat changed while stalled");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Only the final beat carries a length.
  a_len_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.tour_length == '0)
    else $error("length on a non-final beat");

  // An empty-store error is always a lone final beat at city 0.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == nnt_pkg::ST_EMPTY |->
      out_data.last && out_data.city_index == '0)
    else $error("malformed empty-store beat");

  // No input is taken while a result waits.
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while a result waits");
endmodule

bind nearest_neighbour_tour nnt_checker u_nnt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ----- dv/tb_nearest_neighbour_tour.sv -----
// Self-checking testbench for the greedy nearest-neighbor tour block.
// Depends on nnt_pkg and the nearest_neighbour_tour RTL; a built-in tour predictor checks results.
`timescale 1ns / 1ps
`default_nettype none
module tb_nearest_neighbour_tour;
  localparam int NCITY = 64;
  localparam logic [1:0] CMD_BAD = 2'd3;
  localparam longint CYCLE_LIMIT = 3_000_000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               out_stall = 1'b0;
  nnt_pkg::in_beat_t  in_data = '0;
  logic               in_stall;
  logic               out_valid;
  nnt_pkg::out_beat_t out_data;

  nearest_neighbour_tour dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // Predictor state: a private copy of the city store.
  logic signed [23:0] city_x [NCITY];
  logic signed [23:0] city_y [NCITY];
  int                 n_cities;
  bit                 drop_seen;
  nnt_pkg::out_beat_t tour_q[$];

  int     mismatches;
  bit     failed;
  longint cycles;
  int     hold_len;   // receiver hold-off requested by the stimulus
  bit     busy_free;  // stretch with no idling on either side

  function automatic longint unsigned dist_sq(int a, int b);
    longint dx, dy;
    dx = longint'(city_x[b]) - longint'(city_x[a]);
    dy = longint'(city_y[b]) - longint'(city_y[a]);
    return longint'(dx * dx) + longint'(dy * dy);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Apply one command to the predictor and queue the tour it produces.
  task automatic predict_tour(input nnt_pkg::in_beat_t b);
    bit                 seen [NCITY];
    int                 cur, best;
    longint unsigned    best_d, d, total;
    logic [1:0]         st;
    nnt_pkg::out_beat_t r;
    case (b.command)
      nnt_pkg::CMD_LOAD: begin
        if (n_cities < NCITY) begin
          city_x[n_cities] = b.coord_x;
          city_y[n_cities] = b.coord_y;
          n_cities++;
        end else begin
          drop_seen = 1'b1;
        end
      end
      nnt_pkg::CMD_CLEAR: begin
        n_cities = 0;
        drop_seen = 1'b0;
      end
      nnt_pkg::CMD_RUN: begin
        if (n_cities == 0) begin
          r = '{city_index: 6'd0, tour_length: 31'd0, last: 1'b1,
                status: nnt_pkg::ST_EMPTY};
          tour_q.push_back(r);
        end else begin
          st = drop_seen ? nnt_pkg::ST_DROPPED : nnt_pkg::ST_OK;
          foreach (seen[i]) seen[i] = 1'b0;
          seen[0] = 1'b1;
          cur = 0;
          total = 0;
          for (int p = 1; p < n_cities; p++) begin
            best = -1;
            best_d = 0;
            for (int i = 0; i < n_cities; i++) begin
              if (seen[i]) continue;
              d = dist_sq(cur, i);
              if (best < 0 || d < best_d) begin
                best = i;
                best_d = d;
              end
            end
            r = '{city_index: cur[5:0], tour_length: 31'd0, last: 1'b0, status: st};
            tour_q.push_back(r);
            total += int_sqrt(best_d);
            if (total > nnt_pkg::LEN_MAX) total = nnt_pkg::LEN_MAX;
            seen[best] = 1'b1;
            cur = best;
          end
          total += int_sqrt(dist_sq(cur, 0));
          if (total > nnt_pkg::LEN_MAX) total = nnt_pkg::LEN_MAX;
          r = '{city_index: cur[5:0], tour_length: total[30:0], last: 1'b1, status: st};
          tour_q.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // Result checker against the oldest expected beat.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (tour_q.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        nnt_pkg::out_beat_t e;
        e = tour_q.pop_front();
        if (out_data !== e) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", e, out_data);
        end
      end
    end
  end

  // Receiver: random stalls, a long hold-off when asked, none in a busy-free stretch.
  always @(posedge clk) begin
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len <= hold_len - 1;
    end else if (busy_free) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 25);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** nearest_neighbour_tour: FAILED **");
      $finish;
    end
  end

  // Offer one beat and hold it until accepted; valid drops only when idling.
  task automatic send_beat(input nnt_pkg::in_beat_t b);
    while (!busy_free && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tour(b);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tour_q.size() != 0) @(posedge clk);
  endtask

  function automatic nnt_pkg::in_beat_t mk(input logic [1:0] c, input int x, input int y);
    nnt_pkg::in_beat_t b;
    b.command = c;
    b.coord_x = x[23:0];
    b.coord_y = y[23:0];
    return b;
  endfunction

  function automatic nnt_pkg::in_beat_t rand_city(input int spread);
    return mk(nnt_pkg::CMD_LOAD, $urandom_range(2 * spread) - spread,
              $urandom_range(2 * spread) - spread);
  endfunction

  // Directed stimulus table; entries with fixed results are noted.
  nnt_pkg::in_beat_t directed [$];
  int                nc, spread;

  initial begin
    mismatches = 0;
    failed = 1'b0;
    cycles = 0;
    hold_len = 0;
    busy_free = 1'b0;
    n_cities = 0;
    drop_seen = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed = '{
      mk(nnt_pkg::CMD_RUN, 0, 0),                 // empty store: city 0, length 0, status empty
      mk(CMD_BAD, 5, 5),                          // unknown command is ignored
      mk(nnt_pkg::CMD_LOAD, 100, -100),
      mk(nnt_pkg::CMD_RUN, 0, 0),                 // single city: length 0, last
      mk(nnt_pkg::CMD_LOAD, -8388608, -8388608),  // extremes of both coordinates
      mk(nnt_pkg::CMD_LOAD, 8388607, 8388607),
      mk(nnt_pkg::CMD_LOAD, 8388607, -8388608),
      mk(nnt_pkg::CMD_RUN, 0, 0),                 // longest legs the coordinates allow
      mk(nnt_pkg::CMD_CLEAR, 0, 0),
      mk(nnt_pkg::CMD_LOAD, 0, 0),
      mk(nnt_pkg::CMD_LOAD, 256, 0),              // tie: equal distances, lower index wins
      mk(nnt_pkg::CMD_LOAD, -256, 0),
      mk(nnt_pkg::CMD_LOAD, 0, 256),
      mk(nnt_pkg::CMD_RUN, 0, 0),
      mk(nnt_pkg::CMD_LOAD, 0, 0),                // duplicate point, zero-length leg
      mk(nnt_pkg::CMD_RUN, 0, 0),
      mk(nnt_pkg::CMD_CLEAR, 0, 0),
      mk(nnt_pkg::CMD_RUN, 0, 0)                  // empty again after clear
    };
    foreach (directed[i]) send_beat(directed[i]);
    wait_drained();

    // Fill past capacity so loads are dropped and flagged.
    for (int i = 0; i < NCITY + 3; i++) send_beat(rand_city(1 << 20));
    send_beat(mk(nnt_pkg::CMD_RUN, 0, 0));
    // Long receiver hold-off while the sender keeps offering.
    hold_len = 400;
    send_beat(mk(nnt_pkg::CMD_CLEAR, 0, 0));
    for (int i = 0; i < 5; i++) send_beat(rand_city(4096));
    send_beat(mk(nnt_pkg::CMD_RUN, 0, 0));
    send_beat(mk(nnt_pkg::CMD_LOAD, 1, 1));
    wait_drained();

    // Random tours, mostly small; a stretch with no idling in the middle.
    for (int t = 0; t < 4; t++) begin
      busy_free = (t >= 1 && t < 3);
      send_beat(mk(nnt_pkg::CMD_CLEAR, 0, 0));
      nc = ($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(8, 1);
      spread = ($urandom_range(3) == 0) ? 8388607 : $urandom_range(1 << 12, 16);
      for (int i = 0; i < nc; i++) begin
        if ($urandom_range(19) == 0) send_beat(mk(CMD_BAD, $urandom, $urandom));
        send_beat(rand_city(spread));
      end
      send_beat(mk(nnt_pkg::CMD_RUN, 0, 0));
      if ($urandom_range(3) == 0) send_beat(mk(nnt_pkg::CMD_LOAD, $urandom, $urandom));
      if ($urandom_range(3) == 0) send_beat(mk(nnt_pkg::CMD_RUN, 0, 0));
    end
    busy_free = 1'b0;
    wait_drained();
    repeat (50) @(posedge clk);

    if (!failed && tour_q.size() == 0) begin
      $display("** nearest_neighbour_tour: PASSED **");
    end else begin
      $display("** nearest_neighbour_tour: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire
